### rtl/gld_pkg.sv
// Shared types, constants and the button map of the gamepad link report decoder.
`timescale 1ns / 1ps
package gld_pkg;

  localparam logic [7:0] OK_BYTE     = 8'h80;
  localparam logic [7:0] OP_REPORTS  = 8'hAD;
  localparam logic [7:0] OP_LED_MODE = 8'hE4;
  localparam logic [7:0] REPORTS_ON  = 8'h01;
  localparam logic [7:0] LED_RESET   = 8'h02;

  localparam int unsigned NUM_KEYS  = 12;
  localparam int unsigned FRAME_LEN = 6;
  localparam int unsigned STORE_LEN = FRAME_LEN - 1;
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // Link phase codes
  localparam logic [1:0] PH_REPORT  = 2'd0;
  localparam logic [1:0] PH_WAIT_LED = 2'd1;
  localparam logic [1:0] PH_WAIT_REP = 2'd2;

  // Result kinds as they appear on the result port
  localparam logic [1:0] RK_CMD    = 2'd0;
  localparam logic [1:0] RK_AXIS   = 2'd1;
  localparam logic [1:0] RK_BUTTON = 2'd2;
  localparam logic [1:0] RK_ERROR  = 2'd3;

  typedef enum logic [1:0] {
    JOB_LED,
    JOB_REPORTS,
    JOB_ERROR,
    JOB_FRAME
  } job_kind_e;

  // One unit of work handed from the front to the back
  typedef struct packed {
    job_kind_e              kind;
    logic [7:0]             cmd_arg;
    logic [3:0][7:0]        axis;
    logic [NUM_KEYS-1:0]    changed;
    logic [NUM_KEYS-1:0]    level;
  } job_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  cmd_first;
    logic [7:0]  cmd_second;
    logic [3:0][7:0] axis;
    logic [3:0]  key_index;
    logic        pressed;
    logic        last;
  } res_t;

  // Raw frame bit (bytes 4 and 5) that drives each button, in key order
  function automatic logic [3:0] key_bit(input logic [3:0] idx);
    logic [3:0] b;
    case (idx)
      4'd0:    b = 4'd2;
      4'd1:    b = 4'd1;
      4'd2:    b = 4'd3;
      4'd3:    b = 4'd0;
      4'd4:    b = 4'd4;
      4'd5:    b = 4'd11;
      4'd6:    b = 4'd12;
      4'd7:    b = 4'd13;
      4'd8:    b = 4'd14;
      4'd9:    b = 4'd8;
      4'd10:   b = 4'd10;
      4'd11:   b = 4'd9;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

### rtl/gld_front.sv
// Front end: link handshake, frame gathering and job generation.
`timescale 1ns / 1ps
module gld_front import gld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  input  logic       end_of_packet_i,
  input  logic [7:0] led_mode_i,
  output logic       job_push_o,
  output job_t       job_o
);

  logic [1:0]  phase_q, phase_d;
  logic        discard_q, discard_d;
  logic [2:0]  count_q, count_d;
  logic [15:0] prev_q, prev_d;
  logic [7:0]  store_q [STORE_LEN];
  logic        store_we;
  logic [15:0] now_w;
  logic [15:0] diff_w;

  assign now_w  = {rx_byte_i, store_q[STORE_LEN-1]};
  assign diff_w = now_w ^ prev_q;

  always_comb begin
    phase_d    = phase_q;
    discard_d  = discard_q;
    count_d    = count_q;
    prev_d     = prev_q;
    store_we   = 1'b0;
    job_push_o = 1'b0;
    job_o.kind    = JOB_ERROR;
    job_o.cmd_arg = REPORTS_ON;
    for (int i = 0; i < 4; i++) begin
      job_o.axis[i] = store_q[i];
    end
    for (int i = 0; i < NUM_KEYS; i++) begin
      job_o.changed[i] = diff_w[key_bit(4'(i))];
      job_o.level[i]   = now_w[key_bit(4'(i))];
    end
    if (accept_i) begin
      if (!action_i) begin
        job_push_o    = 1'b1;
        job_o.kind    = JOB_LED;
        job_o.cmd_arg = led_mode_i;
        discard_d     = 1'b0;
        phase_d       = PH_WAIT_LED;
      end else if (discard_q) begin
        // dropping bytes up to the end of the packet
      end else if (phase_q == PH_WAIT_LED || phase_q == PH_WAIT_REP) begin
        if (rx_byte_i != OK_BYTE) begin
          job_push_o = 1'b1;
          job_o.kind = JOB_ERROR;
          discard_d  = 1'b1;
        end else if (phase_q == PH_WAIT_LED) begin
          job_push_o = 1'b1;
          job_o.kind = JOB_REPORTS;
          phase_d    = PH_WAIT_REP;
          discard_d  = 1'b1;
        end else begin
          phase_d = PH_REPORT;
        end
      end else begin
        if (count_q < 3'(STORE_LEN)) begin
          store_we = 1'b1;
          count_d  = count_q + 3'd1;
        end else begin
          job_push_o = 1'b1;
          job_o.kind = JOB_FRAME;
          prev_d     = now_w;
          count_d    = 3'd0;
        end
      end
      if (action_i && end_of_packet_i) begin
        discard_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_REPORT;
      discard_q <= 1'b0;
      count_q   <= 3'd0;
      prev_q    <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      discard_q <= discard_d;
      count_q   <= count_d;
      prev_q    <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q] <= rx_byte_i;
    end
  end

endmodule

### rtl/gld_job_fifo.sv
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module gld_job_fifo import gld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_q, rd_q;
  logic [JOB_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == JOB_CNT_W'(JOB_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [JOB_PTR_W-1:0] bump(input logic [JOB_PTR_W-1:0] p);
    return (p == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : p + JOB_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= bump(wr_q);
      if (do_pop)  rd_q <= bump(rd_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + JOB_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - JOB_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= JOB_CNT_W'(JOB_DEPTH)) else $error("job count out of range");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> cnt_q == $past(cnt_q) - JOB_CNT_W'(1))
    else $error("pop did not drain queue");

endmodule

### rtl/gld_back.sv
// Result sequencer: expands jobs into result transactions, one per cycle unless the output register is held.
`timescale 1ns / 1ps
module gld_back import gld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_empty_i,
  input  job_t job_i,
  output logic job_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  job_t                cur_q;
  logic                cur_valid_q;
  logic                axis_done_q, axis_done_d;
  logic [NUM_KEYS-1:0] mask_q, mask_d;
  logic                out_valid_q;
  res_t                out_q;
  res_t                res_d;
  logic                slot_free, emit, done;
  logic [3:0]          sel;
  logic [NUM_KEYS-1:0] sel_hot;

  assign slot_free = !out_valid_q || pop_i;
  assign emit      = cur_valid_q && slot_free;
  assign job_pop_o = !job_empty_i && (!cur_valid_q || (emit && done));
  assign empty_o   = !out_valid_q;
  assign res_o     = out_q;

  // lowest pending changed button
  always_comb begin
    sel = 4'd0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = 4'(i);
    end
    sel_hot = NUM_KEYS'(1) << sel;
  end

  always_comb begin
    res_d       = '0;
    done        = 1'b1;
    axis_done_d = axis_done_q;
    mask_d      = mask_q;
    res_d.last  = 1'b1;
    case (cur_q.kind)
      JOB_LED: begin
        res_d.result_kind = RK_CMD;
        res_d.cmd_first   = OP_LED_MODE;
        res_d.cmd_second  = cur_q.cmd_arg;
      end
      JOB_REPORTS: begin
        res_d.result_kind = RK_CMD;
        res_d.cmd_first   = OP_REPORTS;
        res_d.cmd_second  = REPORTS_ON;
      end
      JOB_FRAME: begin
        if (!axis_done_q) begin
          res_d.result_kind = RK_AXIS;
          res_d.axis        = cur_q.axis;
          res_d.last        = (mask_q == '0);
          done              = (mask_q == '0);
          axis_done_d       = 1'b1;
        end else begin
          mask_d            = mask_q & ~sel_hot;
          res_d.result_kind = RK_BUTTON;
          res_d.key_index   = sel;
          res_d.pressed     = cur_q.level[sel];
          res_d.last        = (mask_d == '0);
          done              = (mask_d == '0);
        end
      end
      default: begin
        res_d.result_kind = RK_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      axis_done_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (job_pop_o) begin
        cur_valid_q <= 1'b1;
        axis_done_q <= 1'b0;
      end else if (emit) begin
        cur_valid_q <= !done;
        axis_done_q <= axis_done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
    if (job_pop_o) begin
      cur_q  <= job_i;
      mask_q <= job_i.changed;
    end else if (emit) begin
      mask_q <= mask_d;
    end
  end

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.result_kind == RK_CMD || out_q.result_kind == RK_ERROR))
      |-> out_q.last) else $error("command or error transaction without last");
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.result_kind == RK_BUTTON) |-> out_q.key_index <= 4'd11)
    else $error("button index out of range");
  a_pending_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && cur_q.kind == JOB_FRAME && axis_done_q) |-> mask_q != '0)
    else $error("button scan with nothing pending");

endmodule

### rtl/gamepad_link_report_decoder.sv
// Top level of the gamepad link report decoder.
`timescale 1ns / 1ps
// Gamepad link report decoder. Input transactions are link events (action 0,
// link opened) and received bytes (action 1) with an end-of-packet flag. A
// link-opened event emits the LED mode command (0xE4, led_mode) and waits
// for an OK byte 0x80; that OK emits the reports-on command (0xAD, 0x01),
// drops the rest of the packet and waits for a second OK, after which bytes
// are collected into 6-byte frames. A complete frame emits one axis result
// carrying bytes 0..3, followed by one button result per changed mapped
// button in key order; last marks the final result of each input. A non-OK
// byte while awaiting a reply emits an error result and drops the rest of
// the packet. Timing: the front end takes one input per cycle while the
// two-entry job queue has room and classifies it in that same cycle; the
// result sequencer emits one result per cycle while its output register is
// free or being popped, so a frame-closing byte makes up to 13 results (one
// axis plus one per changed button) and every other job makes one. Results
// leave through a registered output stage, so a held-off pop does not stall
// input until the queue fills. led_mode sits at byte addresses 0 to 3 of the
// APB port (paddr bit 2 clear, reset value 2) and reads back; 4 to 7 read 0.
module gamepad_link_report_decoder import gld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        end_of_packet_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  cmd_first_o,
  output logic [7:0]  cmd_second_o,
  output logic [7:0]  axis_zero_o,
  output logic [7:0]  axis_one_o,
  output logic [7:0]  axis_two_o,
  output logic [7:0]  axis_three_o,
  output logic [3:0]  key_index_o,
  output logic        pressed_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] led_mode_q;
  logic       accept;
  logic       job_push, job_full, job_pop, job_empty;
  job_t       job_in, job_head;
  res_t       res;

  assign pready = 1'b1;
  // index 0 is the only register; bit 2 selects the next word slot
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, led_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_mode_q <= LED_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      led_mode_q <= pwdata[7:0];
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  gld_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .action_i        (action_i),
    .rx_byte_i       (rx_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .led_mode_i      (led_mode_q),
    .job_push_o      (job_push),
    .job_o           (job_in)
  );

  gld_job_fifo u_jobs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .empty_o     (job_empty),
    .head_o      (job_head)
  );

  gld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign result_kind_o = res.result_kind;
  assign cmd_first_o   = res.cmd_first;
  assign cmd_second_o  = res.cmd_second;
  assign axis_zero_o   = res.axis[0];
  assign axis_one_o    = res.axis[1];
  assign axis_two_o    = res.axis[2];
  assign axis_three_o  = res.axis[3];
  assign key_index_o   = res.key_index;
  assign pressed_o     = res.pressed;
  assign last_o        = res.last;

endmodule

### test/gamepad_link_report_decoder_tb.sv
// Self-checking testbench for the gamepad link report decoder.
`timescale 1ns / 1ps
module gamepad_link_report_decoder_tb;
  import gld_pkg::*;

  // Stimulus codes for the action field
  localparam logic ACT_OPEN = 1'b0;   // link opened event
  localparam logic ACT_BYTE = 1'b1;   // received byte

  localparam logic [2:0] LED_MODE_ADDR = 3'd0;

  // Raw button bit for each key, key 0 in the low nibble
  localparam logic [47:0] BUTTON_BITS = {4'd9, 4'd10, 4'd8, 4'd14, 4'd13, 4'd12,
                                         4'd11, 4'd4, 4'd0, 4'd3, 4'd1, 4'd2};

  localparam int NUM_ROWS      = 24;
  localparam int SETTLE_CYCLES = 8;       // settle time before the APB access and at the end
  localparam int HOLD_CYCLES   = 150;     // long pop hold-off, fills the job queue
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] ax0;
    logic [7:0] ax1;
    logic [7:0] ax2;
    logic [7:0] ax3;
    logic [3:0] key;
    logic       pressed;
    logic       last;
  } pad_result_t;

  // One row of the directed table; typed rows carry their single result
  typedef struct packed {
    logic       act;
    logic [7:0] rx;
    logic       eop;
    logic       typed;
    logic [1:0] kind;
    logic [7:0] first;
    logic [7:0] second;
  } stim_row_t;

  logic        clk;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        action_i;
  logic [7:0]  rx_byte_i;
  logic        end_of_packet_i;
  logic        empty;
  logic        pop;
  logic [1:0]  result_kind_o;
  logic [7:0]  cmd_first_o;
  logic [7:0]  cmd_second_o;
  logic [7:0]  axis_zero_o;
  logic [7:0]  axis_one_o;
  logic [7:0]  axis_two_o;
  logic [7:0]  axis_three_o;
  logic [3:0]  key_index_o;
  logic        pressed_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gamepad_link_report_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .rx_byte_i       (rx_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .empty           (empty),
    .pop             (pop),
    .result_kind_o   (result_kind_o),
    .cmd_first_o     (cmd_first_o),
    .cmd_second_o    (cmd_second_o),
    .axis_zero_o     (axis_zero_o),
    .axis_one_o      (axis_one_o),
    .axis_two_o      (axis_two_o),
    .axis_three_o    (axis_three_o),
    .key_index_o     (key_index_o),
    .pressed_o       (pressed_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder predictor: own copy of the link state and led_mode
  // ---------------------------------------------------------------------
  logic [7:0]  led_mode_shadow;
  logic [1:0]  phase_now;
  logic        dropping;       // skipping bytes to the end of the packet
  logic [2:0]  frame_fill;
  logic [7:0]  frame_bytes [5];
  logic [15:0] prev_buttons;

  // Results of the latest step
  pad_result_t step_res [13];
  int          step_n;

  pad_result_t pending_results [$];   // expectations, oldest first

  // Run statistics
  int items_fed, results_checked, frames_closed, cmds_seen, errors_seen;
  int led_settings, full_cycles, hold_count, mismatch_count;

  // Receiver idling controls, shared with the stimulus process
  int rx_idle_pct, rx_stall, hold_request, hold_left;
  int tx_gap_pct;
  int cycle_count;

  stim_row_t directed_rows [NUM_ROWS];

  task automatic reset_decoder_model();
    led_mode_shadow = LED_RESET;
    phase_now       = PH_REPORT;
    dropping        = 1'b0;
    frame_fill      = '0;
    prev_buttons    = '0;
    for (int i = 0; i < 5; i++) frame_bytes[i] = '0;
  endtask

  task automatic add_result(input logic [1:0] kind, output int idx);
    idx           = step_n;
    step_res[idx] = '0;
    step_res[idx].kind = kind;
    step_n++;
  endtask

  // Advances the predictor by one input transaction; ignored is set when the
  // byte fell inside a dropped packet tail.
  task automatic step_decoder(input logic act, input logic [7:0] rx, input logic eop,
                              output bit ignored);
    int          idx;
    logic [15:0] now_buttons;
    logic [15:0] diff;
    logic [3:0]  bit_pos;
    step_n  = 0;
    ignored = 1'b0;
    if (act == ACT_OPEN) begin
      // restarts the handshake from any state
      add_result(RK_CMD, idx);
      step_res[idx].first  = OP_LED_MODE;
      step_res[idx].second = led_mode_shadow;
      dropping  = 1'b0;
      phase_now = PH_WAIT_LED;
    end else if (dropping) begin
      ignored = 1'b1;
    end else if (phase_now == PH_WAIT_LED || phase_now == PH_WAIT_REP) begin
      if (rx != OK_BYTE) begin
        add_result(RK_ERROR, idx);
        dropping = 1'b1;
      end else if (phase_now == PH_WAIT_LED) begin
        add_result(RK_CMD, idx);
        step_res[idx].first  = OP_REPORTS;
        step_res[idx].second = REPORTS_ON;
        phase_now = PH_WAIT_REP;
        dropping  = 1'b1;
      end else begin
        phase_now = PH_REPORT;
      end
    end else if (frame_fill < 3'd5) begin
      frame_bytes[frame_fill] = rx;
      frame_fill++;
    end else begin
      now_buttons = {rx, frame_bytes[4]};
      diff        = now_buttons ^ prev_buttons;
      add_result(RK_AXIS, idx);
      step_res[idx].ax0 = frame_bytes[0];
      step_res[idx].ax1 = frame_bytes[1];
      step_res[idx].ax2 = frame_bytes[2];
      step_res[idx].ax3 = frame_bytes[3];
      for (int k = 0; k < 12; k++) begin
        bit_pos = BUTTON_BITS[4*k +: 4];
        if (diff[bit_pos]) begin
          add_result(RK_BUTTON, idx);
          step_res[idx].key     = k[3:0];
          step_res[idx].pressed = now_buttons[bit_pos];
        end
      end
      prev_buttons = now_buttons;
      frame_fill   = '0;
    end
    if (act == ACT_BYTE && eop) dropping = 1'b0;
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Input side: drive at the falling edge, accept at the rising edge
  // ---------------------------------------------------------------------
  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // One input transaction; push stays high on return so back-to-back
  // transactions need no gap.
  task automatic send_item(input logic act, input logic [7:0] rx, input logic eop,
                           input bit use_typed, input pad_result_t typed_res);
    bit ignored;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
      idle_input($urandom_range(1, 19));
    @(negedge clk);
    push            <= 1'b1;
    action_i        <= act;
    rx_byte_i       <= rx;
    end_of_packet_i <= eop;
    @(posedge clk);
    while (full) @(posedge clk);
    step_decoder(act, rx, eop, ignored);
    if (!ignored) items_fed++;
    if (use_typed) begin
      pending_results.push_back(typed_res);
    end else begin
      for (int i = 0; i < step_n; i++) pending_results.push_back(step_res[i]);
    end
  endtask

  task automatic feed(input logic act, input logic [7:0] rx, input logic eop);
    send_item(act, rx, eop, 1'b0, '0);
  endtask

  // Drops push and waits for every expected transaction to come out
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write of led_mode followed by a read back
  task automatic set_led_mode(input logic [7:0] value);
    logic [31:0] readback;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LED_MODE_ADDR;
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    led_mode_shadow = value;
    led_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {24'h0, value}) begin
      mismatch_count++;
      $display("%0t: led_mode readback expected %0h actual %0h", $time, value, readback);
    end
  endtask

  // ---------------------------------------------------------------------
  // Random sequences
  // ---------------------------------------------------------------------
  function automatic logic [7:0] not_ok_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == OK_BYTE) b = 8'($urandom);
    return b;
  endfunction

  task automatic drop_tail();
    repeat ($urandom_range(0, 2)) feed(ACT_BYTE, 8'($urandom), 1'b0);
    feed(ACT_BYTE, 8'($urandom), 1'b1);
  endtask

  // Link open, both OKs, with the odd bad reply mixed in
  task automatic link_handshake();
    feed(ACT_OPEN, 8'($urandom), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) begin
      feed(ACT_BYTE, not_ok_byte(), 1'b0);
      drop_tail();
    end
    if ($urandom_range(0, 3) == 0) begin
      feed(ACT_BYTE, OK_BYTE, 1'b1);
    end else begin
      feed(ACT_BYTE, OK_BYTE, 1'b0);
      drop_tail();
    end
    if ($urandom_range(0, 4) == 0) feed(ACT_BYTE, not_ok_byte(), 1'b1);
    feed(ACT_BYTE, OK_BYTE, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_frame();
    logic [7:0]  axis_val;
    logic [15:0] buttons;
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 4))
        0:       axis_val = 8'h00;
        1:       axis_val = 8'hFF;
        default: axis_val = 8'($urandom);
      endcase
      feed(ACT_BYTE, axis_val, $urandom_range(0, 9) == 0);
    end
    // Buttons: fresh, unchanged, one toggled, or all set/clear
    case ($urandom_range(0, 3))
      0:       buttons = 16'($urandom);
      1:       buttons = prev_buttons;
      2:       buttons = prev_buttons ^ (16'h1 << $urandom_range(0, 15));
      default: buttons = {16{1'($urandom_range(0, 1))}};
    endcase
    feed(ACT_BYTE, buttons[7:0], $urandom_range(0, 9) == 0);
    feed(ACT_BYTE, buttons[15:8], 1'b1);
  endtask

  task automatic random_phase(input int target, input bit with_pressure);
    int  goal;
    bit  held, paused;
    goal   = items_fed + target;
    held   = 1'b0;
    paused = 1'b0;
    while (items_fed < goal) begin
      // stall the result side while input keeps coming
      if (with_pressure && !held && items_fed >= goal - (target * 2) / 3) begin
        hold_request = HOLD_CYCLES;
        held = 1'b1;
      end
      // later pause the input until everything has come out
      if (with_pressure && !paused && items_fed >= goal - target / 3) begin
        drain_results();
        paused = 1'b1;
      end
      if (phase_now != PH_REPORT) begin
        link_handshake();
      end else begin
        case ($urandom_range(0, 19))
          0, 1:    link_handshake();
          2, 3, 4: feed($urandom_range(0, 9) != 0, 8'($urandom),
                        1'($urandom_range(0, 1)));
          default: random_frame();
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random pop bursts and the long hold-off
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left    = hold_request - 1;
      hold_request = 0;
      hold_count++;
      pop <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      pop <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall = $urandom_range(1, 19) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: compare each popped transaction with the oldest one due
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pad_result_t want;
    if (rst_ni && push && full) full_cycles++;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual kind %0d", $time,
                 result_kind_o);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.kind == RK_AXIS) frames_closed++;
        if (want.kind == RK_CMD) cmds_seen++;
        if (want.kind == RK_ERROR) errors_seen++;
        check_field("result_kind", 8'(want.kind), 8'(result_kind_o));
        check_field("cmd_first", want.first, cmd_first_o);
        check_field("cmd_second", want.second, cmd_second_o);
        check_field("axis_zero", want.ax0, axis_zero_o);
        check_field("axis_one", want.ax1, axis_one_o);
        check_field("axis_two", want.ax2, axis_two_o);
        check_field("axis_three", want.ax3, axis_three_o);
        check_field("key_index", 8'(want.key), 8'(key_index_o));
        check_field("pressed", 8'(want.pressed), 8'(pressed_o));
        check_field("last", 8'(want.last), 8'(last_o));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------
  function automatic stim_row_t byte_row(input logic [7:0] rx, input logic eop);
    stim_row_t r;
    r     = '0;
    r.act = ACT_BYTE;
    r.rx  = rx;
    r.eop = eop;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic act, input logic [7:0] rx,
                                          input logic eop, input logic [1:0] kind,
                                          input logic [7:0] first,
                                          input logic [7:0] second);
    stim_row_t r;
    r.act    = act;
    r.rx     = rx;
    r.eop    = eop;
    r.typed  = 1'b1;
    r.kind   = kind;
    r.first  = first;
    r.second = second;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    stim_row_t   row;
    pad_result_t typed_res;

    rst_ni          = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    action_i        = ACT_BYTE;
    rx_byte_i       = '0;
    end_of_packet_i = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rx_idle_pct     = 0;
    rx_stall        = 0;
    hold_request    = 0;
    hold_left       = 0;
    tx_gap_pct      = 0;
    cycle_count     = 0;
    items_fed       = 0;
    results_checked = 0;
    frames_closed   = 0;
    cmds_seen       = 0;
    errors_seen     = 0;
    led_settings    = 1;   // reset value counts as one setting
    full_cycles     = 0;
    hold_count      = 0;
    mismatch_count  = 0;
    reset_decoder_model();

    // Report mode after reset: a frame with every button pressed, then one
    // with every button released (13 results each, axis extremes).
    directed_rows[0]  = byte_row(8'h00, 1'b0);
    directed_rows[1]  = byte_row(8'hFF, 1'b0);
    directed_rows[2]  = byte_row(8'h00, 1'b0);
    directed_rows[3]  = byte_row(8'hFF, 1'b0);
    directed_rows[4]  = byte_row(8'hFF, 1'b0);
    directed_rows[5]  = byte_row(8'hFF, 1'b1);
    directed_rows[6]  = byte_row(8'hFF, 1'b0);
    directed_rows[7]  = byte_row(8'h00, 1'b0);
    directed_rows[8]  = byte_row(8'hFF, 1'b0);
    directed_rows[9]  = byte_row(8'h00, 1'b0);
    directed_rows[10] = byte_row(8'h00, 1'b0);
    directed_rows[11] = byte_row(8'h00, 1'b1);
    // Partial frame, kept across the handshake below
    directed_rows[12] = byte_row(8'h3C, 1'b0);
    // Link open ignores its byte and end flag
    directed_rows[13] = typed_row(ACT_OPEN, 8'hFF, 1'b1, RK_CMD, OP_LED_MODE, LED_RESET);
    // Missing OK, then the packet tail is dropped
    directed_rows[14] = typed_row(ACT_BYTE, 8'h7F, 1'b0, RK_ERROR, 8'h00, 8'h00);
    directed_rows[15] = byte_row(OK_BYTE, 1'b0);
    // Link open mid-handshake restarts it and ends the drop
    directed_rows[16] = typed_row(ACT_OPEN, 8'h00, 1'b0, RK_CMD, OP_LED_MODE, LED_RESET);
    directed_rows[17] = typed_row(ACT_BYTE, OK_BYTE, 1'b0, RK_CMD, OP_REPORTS, REPORTS_ON);
    // Rest of the OK packet is dropped, even an OK
    directed_rows[18] = byte_row(OK_BYTE, 1'b0);
    directed_rows[19] = byte_row(8'h81, 1'b1);
    // Missing second OK
    directed_rows[20] = typed_row(ACT_BYTE, 8'h00, 1'b0, RK_ERROR, 8'h00, 8'h00);
    directed_rows[21] = byte_row(8'hFF, 1'b1);
    // Second OK, and the next byte of its packet is a frame byte
    directed_rows[22] = byte_row(OK_BYTE, 1'b0);
    directed_rows[23] = byte_row(8'h5A, 1'b1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Directed part with the reset value of led_mode
    tx_gap_pct  = 20;
    rx_idle_pct = 6;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row          = directed_rows[i];
      typed_res    = '0;
      typed_res.kind   = row.kind;
      typed_res.first  = row.first;
      typed_res.second = row.second;
      typed_res.last   = 1'b1;
      send_item(row.act, row.rx, row.eop, row.typed, typed_res);
    end

    // led_mode low extreme, heavy idling, long hold-off and an input pause
    set_led_mode(8'h00);
    tx_gap_pct  = 25;
    rx_idle_pct = 8;
    random_phase(100, 1'b1);

    // led_mode high extreme, light idling
    set_led_mode(8'hFF);
    tx_gap_pct  = 8;
    rx_idle_pct = 3;
    random_phase(100, 1'b0);

    // Random led_mode, no idling on either side
    set_led_mode(8'($urandom));
    tx_gap_pct  = 0;
    rx_idle_pct = 0;
    random_phase(90, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d link items: %0d frames, %0d commands, %0d missing-OK errors",
             items_fed, frames_closed, cmds_seen, errors_seen);
    $display("Checked %0d results over %0d led_mode settings; %0d full cycles, %0d hold-offs",
             results_checked, led_settings, full_cycles, hold_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
